// ===== design/lsrd_pkg.sv =====
// ----------------------------------------------------------------------------
// lsrd_pkg
// Shared types and constants for the serial LED driver with output-enable
// dimming: widths, item kinds, register indexes and the divide-by-100 helper.
// ----------------------------------------------------------------------------
`default_nettype none

package lsrd_pkg;

  localparam int LED_COUNT = 8;
  localparam int CNT_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  localparam int BRIGHT_W = 7;
  localparam int PERIOD_W = 10;
  localparam int PROD_W   = BRIGHT_W + PERIOD_W;

  localparam logic [BRIGHT_W-1:0] FULL_PERCENT  = BRIGHT_W'(100);
  localparam logic [PERIOD_W-1:0] RESET_PERIOD  = PERIOD_W'(10);
  localparam logic [PROD_W-1:0]   RESET_PROD_ON = PROD_W'(1000);

  // floor(x / 100) as (x * RECIP_K) >> RECIP_SHIFT, exact for x below 2^17
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_K_W   = 18;
  localparam logic [RECIP_K_W-1:0] RECIP_K = RECIP_K_W'(((1 << RECIP_SHIFT) + 99) / 100);
  localparam int RECIP_P_W   = PROD_W + RECIP_K_W;

  typedef enum logic [1:0] {
    KIND_SET_ONE  = 2'd0,
    KIND_SET_MASK = 2'd1,
    KIND_TICK     = 2'd2
  } kind_t;

  typedef enum logic {
    REG_BRIGHTNESS = 1'b0,
    REG_PERIOD     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                bright_we;
    logic                period_we;
    logic [PERIOD_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic                level_now;
    logic                level_tick;
    logic [BRIGHT_W-1:0] bright;
    logic [PERIOD_W-1:0] period;
  } dim_status_t;

  function automatic logic [PERIOD_W-1:0] div100(input logic [PROD_W-1:0] x);
    logic [RECIP_P_W-1:0] p;
    p = RECIP_P_W'(x) * RECIP_P_W'(RECIP_K);
    return PERIOD_W'(p >> RECIP_SHIFT);
  endfunction

endpackage

`default_nettype wire

// ===== design/led_shift_register_driver_with_dimming.sv =====
// ----------------------------------------------------------------------------
// led_shift_register_driver_with_dimming
// Active-low LED pattern driver: set commands update the pattern and shift it
// out MSB first with a latch on the final bit; ticks step the enable dimming.
// ----------------------------------------------------------------------------
// result words: a set command yields LED_COUNT result words, one per cycle while
//   m_tready is high; ticks and bad indexes yield a single word, unused kinds none;
//   an accepted word waits in the input register until the result register is free
// the input register takes the next word while results still drain
// reset: synchronous, pattern all ones, on phase, brightness 100, period 10
`default_nettype none

module led_shift_register_driver_with_dimming
  import lsrd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // led_number[7:0], led_select_mask[15:8], turn_on[16]
  input  wire logic [1:0]  s_tuser,   // kind[1:0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // serial_bit[0], shift_pulse[1], latch_pulse[2],
                                      // outputs_disabled[3]
  output logic [0:0]       m_tuser,   // bad_index[0]
  output logic             m_tlast,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // input register
  logic                 in_valid;
  kind_t                in_kind;
  logic [7:0]           in_num;
  logic [7:0]           in_mask;
  logic                 in_on;

  // result register
  logic                 out_valid;
  logic                 out_shift;
  logic                 out_bad;
  logic                 out_dis;
  logic [LED_COUNT-1:0] out_bits;
  logic [CNT_W-1:0]     out_cnt;

  logic                 led_pattern, unused_low;
  logic [LED_COUNT-1:0] pattern, pattern_next, sel;
  logic                 out_last, out_free, process;
  logic                 load, load_shift, load_bad, load_dis, tick;

  cfg_wr_t              cfg_wr;
  dim_status_t          dim;
  reg_idx_t             cfg_idx;
  logic                 cfg_we;

  assign led_pattern = pattern[LED_COUNT-1];
  assign unused_low  = ^paddr[1:0] ^ ^pwdata[31:PERIOD_W] ^ led_pattern;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr.bright_we = cfg_we && (cfg_idx == REG_BRIGHTNESS);
  assign cfg_wr.period_we = cfg_we && (cfg_idx == REG_PERIOD);
  assign cfg_wr.data      = pwdata[PERIOD_W-1:0];

  always_comb begin
    case (cfg_idx)
      REG_BRIGHTNESS: prdata = 32'(dim.bright);
      REG_PERIOD:     prdata = 32'(dim.period);
      default:        prdata = '0;
    endcase
  end

  lsrd_dim u_dim (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .tick   (tick),
    .status (dim)
  );

  // handshakes
  assign out_last = (out_cnt == '0);
  assign out_free = !out_valid || (m_tready && out_last);
  assign process  = in_valid && out_free;
  assign s_tready = !in_valid || process;

  // command decode
  always_comb begin
    sel          = LED_COUNT'(in_mask);
    pattern_next = pattern;
    load         = 1'b0;
    load_shift   = 1'b0;
    load_bad     = 1'b0;
    load_dis     = dim.level_now;
    tick         = 1'b0;
    if (process) begin
      case (in_kind)
        KIND_SET_ONE: begin
          load = 1'b1;
          if (in_num >= 8'(LED_COUNT)) begin
            load_bad = 1'b1;
          end else begin
            load_shift   = 1'b1;
            pattern_next = in_on ? (pattern & ~(LED_COUNT'(1) << in_num))
                                 : (pattern |  (LED_COUNT'(1) << in_num));
          end
        end
        KIND_SET_MASK: begin
          load         = 1'b1;
          load_shift   = 1'b1;
          pattern_next = in_on ? (pattern & ~sel) : (pattern | sel);
        end
        KIND_TICK: begin
          load     = 1'b1;
          tick     = 1'b1;
          load_dis = dim.level_tick;
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      out_cnt   <= '0;
      pattern   <= '1;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (process) begin
        in_valid <= 1'b0;
      end
      pattern <= pattern_next;
      if (load) begin
        out_valid <= 1'b1;
        out_cnt   <= load_shift ? CNT_W'(LED_COUNT - 1) : '0;
      end else if (m_tready && out_valid) begin
        if (out_last) begin
          out_valid <= 1'b0;
        end else begin
          out_cnt <= out_cnt - CNT_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= kind_t'(s_tuser);
      in_num  <= s_tdata[7:0];
      in_mask <= s_tdata[15:8];
      in_on   <= s_tdata[16];
    end
    if (load) begin
      out_shift <= load_shift;
      out_bad   <= load_bad;
      out_dis   <= load_dis;
      out_bits  <= load_shift ? pattern_next : '0;
    end else if (m_tready && out_valid) begin
      // msb first
      out_bits <= out_bits << 1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, unused_low & 1'b0, out_dis, out_shift & out_last, out_shift,
                     out_bits[LED_COUNT-1]};
  assign m_tuser  = out_bad;
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

// ===== design/lsrd_dim.sv =====
// ----------------------------------------------------------------------------
// lsrd_dim
// Dimming engine: brightness and period registers, phase lengths, and the
// two-phase output-enable counter advanced by tick items.
// ----------------------------------------------------------------------------
`default_nettype none

module lsrd_dim
  import lsrd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_wr_t     cfg_wr,
  input  wire logic        tick,
  output dim_status_t      status
);

  logic [BRIGHT_W-1:0] bright, bright_sel;
  logic [PERIOD_W-1:0] period, period_sel;
  logic [PROD_W-1:0]   prod_on, prod_off;
  logic [PERIOD_W-1:0] on_len, off_len;
  logic                off_phase, off_phase_next;
  logic [PERIOD_W-1:0] tick_count, tick_count_next;
  logic [PERIOD_W-1:0] count_inc, phase_len;
  logic                bright_ok, dimming;

  function automatic logic level_of(input logic [BRIGHT_W-1:0] b,
                                    input logic [PERIOD_W-1:0] a_len,
                                    input logic [PERIOD_W-1:0] b_len,
                                    input logic ph);
    logic lvl;
    if (b >= FULL_PERCENT)                      lvl = 1'b0;
    else if (b == '0)                           lvl = 1'b1;
    else if (a_len == '0 && b_len == '0)        lvl = 1'b0;
    else if (a_len == '0)                       lvl = 1'b1;
    else if (b_len == '0)                       lvl = 1'b0;
    else                                        lvl = ph;
    return lvl;
  endfunction

  assign bright_ok  = cfg_wr.bright_we && (cfg_wr.data[BRIGHT_W-1:0] <= FULL_PERCENT);
  assign bright_sel = bright_ok ? cfg_wr.data[BRIGHT_W-1:0] : bright;
  assign period_sel = cfg_wr.period_we ? cfg_wr.data : period;

  assign dimming = (bright != '0) && (bright < FULL_PERCENT) &&
                   (on_len != '0) && (off_len != '0);

  always_comb begin
    count_inc       = tick_count + PERIOD_W'(1);
    phase_len       = off_phase ? off_len : on_len;
    off_phase_next  = off_phase;
    tick_count_next = tick_count;
    if (tick) begin
      if (!dimming) begin
        off_phase_next  = 1'b0;
        tick_count_next = '0;
      end else if (count_inc >= phase_len || count_inc == '0) begin
        off_phase_next  = ~off_phase;
        tick_count_next = '0;
      end else begin
        tick_count_next = count_inc;
      end
    end
    // duty of 0 or 100 stops dimming
    if (bright_ok && (cfg_wr.data[BRIGHT_W-1:0] == '0 ||
                      cfg_wr.data[BRIGHT_W-1:0] == FULL_PERCENT)) begin
      off_phase_next  = 1'b0;
      tick_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bright     <= FULL_PERCENT;
      period     <= RESET_PERIOD;
      prod_on    <= RESET_PROD_ON;
      prod_off   <= '0;
      on_len     <= RESET_PERIOD;
      off_len    <= '0;
      off_phase  <= 1'b0;
      tick_count <= '0;
    end else begin
      bright     <= bright_sel;
      period     <= period_sel;
      // one product per cycle, the reciprocal divide on the next
      prod_on    <= PROD_W'(bright_sel) * PROD_W'(period_sel);
      prod_off   <= PROD_W'(FULL_PERCENT - bright_sel) * PROD_W'(period_sel);
      on_len     <= div100(prod_on);
      off_len    <= div100(prod_off);
      off_phase  <= off_phase_next;
      tick_count <= tick_count_next;
    end
  end

  assign status.level_now  = level_of(bright, on_len, off_len, off_phase);
  assign status.level_tick = level_of(bright, on_len, off_len, off_phase_next);
  assign status.bright     = bright;
  assign status.period     = period;

endmodule

`default_nettype wire

// ===== verif/led_shift_register_driver_with_dimming_test.sv =====
// ----------------------------------------------------------------------------
// led_shift_register_driver_with_dimming_test
// Self-checking bench for the serial LED driver: drives set-one, set-mask,
// tick and unused-kind words with random gaps and back-pressure, predicts
// every result word from its own model of the pattern and dimming phases,
// and steps the brightness and period registers through a range of settings.
// ----------------------------------------------------------------------------
`default_nettype none

module led_shift_register_driver_with_dimming_test;
  import lsrd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_PAD  = 8;
  localparam int STALL_LIMIT = 3000;
  localparam int RAND_PER_SETTING = 36;
  localparam int NUM_ROWS = 18;
  localparam int NUM_SETTINGS = 12;

  // one result word as seen on the master side, tdata bits first
  typedef struct packed {
    logic [3:0] pad;
    logic       dis;
    logic       latch;
    logic       shift;
    logic       serial;
    logic       bad;
    logic       last;
  } led_word_t;

  typedef struct packed {
    logic       none;
    logic       shift;
    logic       bad;
    logic [7:0] pat;
    logic       dis;
  } led_step_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] num;
    logic [7:0] mask;
    logic       on;
    logic       typed;
    logic [7:0] pat;
    logic       dis;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] bright;
    logic [31:0] period;
  } dim_setting_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  led_shift_register_driver_with_dimming i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  // model state
  logic [7:0] led_pat = 8'hFF;
  logic       in_off_phase = 1'b0;
  logic [9:0] phase_count = '0;
  logic [6:0] bright_pct = 7'd100;
  logic [9:0] period_ticks = 10'd10;

  led_word_t due_words[$];
  led_word_t got_word;
  led_word_t want_word;

  int fail_count = 0;
  int words_sent = 0;
  int ticks_sent = 0;
  int words_checked = 0;
  int send_idle_pct = 8;
  int recv_idle_pct = 70;
  int quiet_cycles = 0;

  // kind, led_number, mask, turn_on, typed, pattern, outputs_disabled
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{KIND_SET_MASK, 8'h00, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0},
    '{KIND_SET_MASK, 8'h00, 8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0},
    '{KIND_SET_ONE,  8'h00, 8'h00, 1'b1, 1'b1, 8'hFE, 1'b0},
    '{KIND_SET_ONE,  8'h07, 8'hFF, 1'b1, 1'b1, 8'h7E, 1'b0},
    '{KIND_SET_ONE,  8'h08, 8'h00, 1'b1, 1'b1, 8'h7E, 1'b0},
    '{KIND_SET_ONE,  8'hFF, 8'hFF, 1'b0, 1'b1, 8'h7E, 1'b0},
    '{KIND_TICK,     8'hFF, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0},
    '{KIND_UNUSED,   8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
    '{KIND_SET_ONE,  8'h07, 8'h00, 1'b0, 1'b1, 8'hFE, 1'b0},
    '{KIND_SET_MASK, 8'hFF, 8'h00, 1'b1, 1'b1, 8'hFE, 1'b0},
    '{KIND_SET_MASK, 8'h00, 8'hA5, 1'b1, 1'b1, 8'h5A, 1'b0},
    '{KIND_SET_MASK, 8'h00, 8'h0F, 1'b0, 1'b0, 8'h00, 1'b0},
    '{KIND_SET_ONE,  8'h03, 8'h5A, 1'b1, 1'b0, 8'h00, 1'b0},
    '{KIND_TICK,     8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{KIND_UNUSED,   8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{KIND_SET_ONE,  8'h04, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{KIND_SET_MASK, 8'h80, 8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
    '{KIND_SET_MASK, 8'h7F, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0}
  };

  // brightness then period; 101 is out of range and must be dropped,
  // the third 50 keeps the phase and shortens the period under it
  dim_setting_t dim_settings [NUM_SETTINGS] = '{
    '{32'd50,  32'd4},
    '{32'd25,  32'd8},
    '{32'd50,  32'd20},
    '{32'd50,  32'd4},
    '{32'd0,   32'd10},
    '{32'd1,   32'd10},
    '{32'd99,  32'd10},
    '{32'd50,  32'd1},
    '{32'd101, 32'd7},
    '{32'd73,  32'd1000},
    '{32'd100, 32'd1000},
    '{32'd7,   32'd30}
  };

  function automatic int on_ticks();
    return (int'(bright_pct) * int'(period_ticks)) / 100;
  endfunction

  function automatic int off_ticks();
    return ((100 - int'(bright_pct)) * int'(period_ticks)) / 100;
  endfunction

  function automatic logic oe_level();
    int a;
    int b;
    a = on_ticks();
    b = off_ticks();
    if (bright_pct >= FULL_PERCENT) return 1'b0;
    if (bright_pct == 0) return 1'b1;
    if (a == 0 && b == 0) return 1'b0;
    if (a == 0) return 1'b1;
    if (b == 0) return 1'b0;
    return in_off_phase;
  endfunction

  function automatic void dim_tick();
    int a;
    int b;
    int len;
    a = on_ticks();
    b = off_ticks();
    if (bright_pct == 0 || bright_pct >= FULL_PERCENT || a == 0 || b == 0) begin
      in_off_phase = 1'b0;
      phase_count = '0;
    end else begin
      len = in_off_phase ? b : a;
      phase_count = phase_count + 10'd1;
      // a count left past a shortened phase flips on the next tick
      if (int'(phase_count) >= len || phase_count == 0) begin
        in_off_phase = ~in_off_phase;
        phase_count = '0;
      end
    end
  endfunction

  function automatic void dim_cfg_write(input reg_idx_t idx, input logic [31:0] v);
    if (idx == REG_BRIGHTNESS) begin
      if (v[6:0] <= FULL_PERCENT) begin
        bright_pct = v[6:0];
        if (v[6:0] == 0 || v[6:0] == FULL_PERCENT) begin
          in_off_phase = 1'b0;
          phase_count = '0;
        end
      end
    end else begin
      period_ticks = v[9:0];
    end
  endfunction

  function automatic led_step_t led_step(input logic [1:0] kind, input logic [7:0] num,
                                         input logic [7:0] mask, input logic on);
    led_step_t s;
    s = '0;
    case (kind)
      KIND_SET_ONE: begin
        if (num >= LED_COUNT) begin
          s.bad = 1'b1;
        end else begin
          led_pat[num[2:0]] = ~on;
          s.shift = 1'b1;
        end
      end
      KIND_SET_MASK: begin
        led_pat = on ? (led_pat & ~mask) : (led_pat | mask);
        s.shift = 1'b1;
      end
      KIND_TICK: begin
        dim_tick();
      end
      default: begin
        s.none = 1'b1;
      end
    endcase
    s.pat = led_pat;
    s.dis = oe_level();
    return s;
  endfunction

  function automatic void queue_words(input led_step_t s);
    led_word_t w;
    if (s.none) return;
    if (s.shift) begin
      for (int k = 0; k < LED_COUNT; k++) begin
        w = '0;
        w.serial = s.pat[LED_COUNT-1-k];
        w.shift  = 1'b1;
        w.latch  = (k == LED_COUNT - 1);
        w.last   = w.latch;
        w.dis    = s.dis;
        due_words.push_back(w);
      end
    end else begin
      w = '0;
      w.dis  = s.dis;
      w.bad  = s.bad;
      w.last = 1'b1;
      due_words.push_back(w);
    end
  endfunction

  task automatic report_word(input string what, input led_word_t got, input led_word_t want);
    if (fail_count < 40)
      $display("%0t %s: got %b, want %b (pad, dis, latch, shift, bit, bad, last)",
               $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic send_word(input logic [1:0] kind, input logic [7:0] num,
                           input logic [7:0] mask, input logic on, input logic typed,
                           input logic [7:0] tpat, input logic tdis);
    led_step_t s;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s = led_step(kind, num, mask, on);
    if (typed) begin
      s.pat = tpat;
      s.dis = tdis;
    end
    queue_words(s);
    if (kind != KIND_UNUSED) words_sent++;
    if (kind == KIND_TICK) ticks_sent++;
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, on, mask, num};
    s_tuser  <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop sending, let every due word come back, then let the design settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_PAD) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    dim_cfg_write(idx, v);
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_word = {m_tdata, m_tuser[0], m_tlast};
      words_checked++;
      if (due_words.size() == 0) begin
        report_word("unexpected word", got_word, '0);
      end else begin
        want_word = due_words.pop_front();
        if (got_word != want_word) report_word("word mismatch", got_word, want_word);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d still due",
               quiet_cycles, due_words.size());
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    int r;
    logic [1:0] kind;
    logic [7:0] num;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++)
      send_word(directed_rows[i].kind, directed_rows[i].num, directed_rows[i].mask,
                directed_rows[i].on, directed_rows[i].typed, directed_rows[i].pat,
                directed_rows[i].dis);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s == 4) begin
        send_idle_pct = 70;
        recv_idle_pct = 8;
      end else if (s == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_results();
      apb_write(REG_BRIGHTNESS, dim_settings[s].bright);
      apb_write(REG_PERIOD, dim_settings[s].period);
      n = 0;
      while (n < RAND_PER_SETTING) begin
        r = $urandom_range(99);
        num = 8'($urandom_range(255));
        if (r < 45) begin
          kind = KIND_TICK;
        end else if (r < 70) begin
          kind = KIND_SET_ONE;
          num = ($urandom_range(7) == 0) ? 8'($urandom_range(255, 8)) : 8'($urandom_range(7));
        end else if (r < 95) begin
          kind = KIND_SET_MASK;
        end else begin
          kind = KIND_UNUSED;
        end
        send_word(kind, num, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0, 1'b0);
        if (kind != KIND_UNUSED) n++;
        if (s == 2 && n == RAND_PER_SETTING / 2) drain_results();
      end
    end

    drain_results();
    $display("summary: %0d input words (%0d ticks), %0d result words checked",
             words_sent, ticks_sent, words_checked);
    $display("summary: %0d dimming settings, duty 0 to 100 with a dropped write, period 1 to 1000",
             NUM_SETTINGS);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
